// File: rtl/core/hrds_pkg.sv
// Shared types, codes and constants of the heart-rate driver-state block.
// No dependencies; every other file of the block refers to this package.
package hrds_pkg;

  localparam int TAP_COUNT = 9;

  localparam logic [15:0] RATE_RESET = 16'd15360;
  localparam logic [15:0] PCT_MAX    = 16'hFFFF;

  localparam logic [15:0] COEF_RESET      = 16'd58982;
  localparam logic [15:0] RATE_LOW_RESET  = 16'd12800;
  localparam logic [15:0] RATE_HIGH_RESET = 16'd25600;
  localparam logic [15:0] VAR_LOW_RESET   = 16'd6400;
  localparam logic [15:0] VAR_HIGH_RESET  = 16'd7680;

  localparam logic [2:0] REG_COEF      = 3'd0;
  localparam logic [2:0] REG_RATE_LOW  = 3'd1;
  localparam logic [2:0] REG_RATE_HIGH = 3'd2;
  localparam logic [2:0] REG_VAR_LOW   = 3'd3;
  localparam logic [2:0] REG_VAR_HIGH  = 3'd4;

  localparam logic [2:0] GAZE_FOCUS  = 3'd0;
  localparam logic [2:0] GAZE_LEFT   = 3'd1;
  localparam logic [2:0] GAZE_RIGHT  = 3'd2;
  localparam logic [2:0] GAZE_CLOSED = 3'd3;

  localparam logic [1:0] CLS_NORMAL  = 2'd0;
  localparam logic [1:0] CLS_WARNING = 2'd1;
  localparam logic [1:0] CLS_STOP    = 2'd2;

  localparam logic [2:0] SYM_NONE     = 3'd0;
  localparam logic [2:0] SYM_STOP     = 3'd1;
  localparam logic [2:0] SYM_HEART    = 3'd2;
  localparam logic [2:0] SYM_QUESTION = 3'd3;
  localparam logic [2:0] SYM_SMILE    = 3'd4;

  typedef struct packed {
    logic [15:0] rate_sample;
    logic [2:0]  gaze_class;
  } in_word_t;

  typedef struct packed {
    logic [15:0] smoothed_rate;
    logic [15:0] variability_pct;
    logic [1:0]  driver_class;
    logic [2:0]  display_symbol;
    logic        fixed_brightness;
    logic        rule_hit;
    logic        alert;
  } out_word_t;

  typedef struct packed {
    logic [15:0] rate_low;
    logic [15:0] rate_high;
    logic [15:0] var_low;
    logic [15:0] var_high;
  } limits_t;

  typedef struct packed {
    logic [1:0] driver_class;
    logic [2:0] display_symbol;
    logic       fixed_brightness;
    logic       rule_hit;
    logic       alert;
  } decision_t;

  typedef struct packed {
    logic en;
    logic init;
    logic round;
  } mac_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Derivative taps in Q1.15, oldest sample first.
  function automatic logic signed [17:0] fir_tap(input logic [3:0] idx);
    logic signed [17:0] t;
    case (idx)
      4'd0:    t = -18'sd546;
      4'd1:    t = -18'sd2185;
      4'd2:    t = -18'sd1638;
      4'd3:    t = -18'sd1092;
      4'd4:    t = 18'sd0;
      4'd5:    t = 18'sd546;
      4'd6:    t = 18'sd1092;
      4'd7:    t = 18'sd1638;
      4'd8:    t = 18'sd2185;
      default: t = 18'sd0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/heart_rate_driver_state_top.sv
// Heart-rate driver-state block: sequencer, state and configuration registers.
// Depends on hrds_pkg, hrds_mac, hrds_div and hrds_decide.
// Each input word passes through the shared multiply-accumulate unit
// (11 products) and the one-bit-a-cycle divider (16 steps); the divider is
// skipped when the variability saturates. A new word is accepted only after
// the last result word has been handed to the output register; in_ready is
// high only when idle.
// Reset (synchronous, active low) restores the registers to their defaults, the
// average and all eight past samples to 60 bpm, and the last driver class to normal.
module heart_rate_driver_state_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hrds_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hrds_pkg::out_word_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // Sequencer states: IDLE, AVG, FIR, SCALE, DINIT, DIV (skipped on saturation), DONE.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_AVG   = 3'd1;
  localparam logic [2:0] ST_FIR   = 3'd2;
  localparam logic [2:0] ST_SCALE = 3'd3;
  localparam logic [2:0] ST_DINIT = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam int          DEPTH    = hrds_pkg::TAP_COUNT - 1;
  localparam logic [3:0]  AVG_LAST = 4'd1;
  localparam logic [3:0]  FIR_LAST = 4'(hrds_pkg::TAP_COUNT - 1);
  localparam logic [3:0]  DIV_LAST = 4'd15;

  logic [2:0]  state_r;
  logic [2:0]  state_nxt;
  logic [3:0]  cnt_r;
  logic [3:0]  cnt_nxt;

  // Configuration registers.
  logic [15:0]         coef_r;
  hrds_pkg::limits_t   lim_r;

  // Block state carried from item to item.
  logic [15:0] avg_r;
  logic [15:0] past_r [DEPTH];
  logic [1:0]  last_class_r;

  // Working registers of the item in flight.
  logic [15:0] x_r;
  logic [2:0]  gaze_r;
  logic [29:0] num_r;
  logic        sat_r;

  logic                out_valid_r;
  hrds_pkg::out_word_t out_r;

  hrds_pkg::mac_ctrl_t mac_ctrl;
  hrds_pkg::div_ctrl_t div_ctrl;
  logic signed [17:0]  mac_a;
  logic [15:0]         mac_b;
  logic signed [34:0]  acc;
  logic [16:0]         coef_comp;
  logic [34:0]         mag_full;
  logic [29:0]         mag;
  logic [36:0]         scaled;
  logic                over;
  logic [15:0]         quotient;
  logic [15:0]         pct;
  logic                finish;
  hrds_pkg::decision_t dec;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The finished word may only leave DONE once the output register is free.
  assign finish = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_AVG;
          cnt_nxt   = '0;
        end
      end
      ST_AVG: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == AVG_LAST) begin
          state_nxt = ST_FIR;
          cnt_nxt   = '0;
        end
      end
      ST_FIR: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == FIR_LAST) begin
          state_nxt = ST_SCALE;
          cnt_nxt   = '0;
        end
      end
      ST_SCALE: begin
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        state_nxt = over ? ST_DONE : ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Operand selection for the shared multiplier. The average takes two products,
  // k times the old average and (1 - k) times the sample; the filter takes nine.
  assign coef_comp = 17'h10000 - {1'b0, coef_r};

  always_comb begin
    mac_ctrl = '0;
    mac_a    = '0;
    mac_b    = '0;
    if (state_r == ST_AVG) begin
      mac_ctrl.en    = 1'b1;
      mac_ctrl.init  = (cnt_r == 4'd0);
      mac_ctrl.round = 1'b1;
      if (cnt_r == 4'd0) begin
        mac_a = $signed({2'b00, coef_r});
        mac_b = avg_r;
      end else begin
        mac_a = $signed({1'b0, coef_comp});
        mac_b = x_r;
      end
    end else if (state_r == ST_FIR) begin
      mac_ctrl.en   = 1'b1;
      mac_ctrl.init = (cnt_r == 4'd0);
      mac_a         = hrds_pkg::fir_tap(cnt_r);
      mac_b         = (cnt_r == FIR_LAST) ? x_r : past_r[cnt_r[2:0]];
    end
  end

  hrds_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // Magnitude of the filter sum; it stays below 2^30 for any input.
  assign mag_full = acc[34] ? 35'(-acc) : 35'(acc);
  assign mag      = mag_full[29:0];
  // Times 100 by shifts and adds; the divide by 128 is taken up front, which
  // leaves the floor of the quotient unchanged.
  assign scaled   = ({7'd0, mag} << 6) + ({7'd0, mag} << 5) + ({7'd0, mag} << 2);

  // A quotient that would not fit in 16 bits, a zero average included, saturates.
  assign over = {2'b00, num_r} >= {avg_r, 16'h0000};

  assign div_ctrl.load = (state_r == ST_DINIT);
  assign div_ctrl.step = (state_r == ST_DIV);

  hrds_div u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend ({2'b00, num_r}),
    .divisor  (avg_r),
    .quotient (quotient)
  );

  assign pct = sat_r ? hrds_pkg::PCT_MAX : quotient;

  hrds_decide u_decide (
    .rate       (x_r),
    .gaze       (gaze_r),
    .pct        (pct),
    .lim        (lim_r),
    .last_class (last_class_r),
    .dec        (dec)
  );

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      out_valid_r     <= 1'b0;
      coef_r          <= hrds_pkg::COEF_RESET;
      lim_r.rate_low  <= hrds_pkg::RATE_LOW_RESET;
      lim_r.rate_high <= hrds_pkg::RATE_HIGH_RESET;
      lim_r.var_low   <= hrds_pkg::VAR_LOW_RESET;
      lim_r.var_high  <= hrds_pkg::VAR_HIGH_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          hrds_pkg::REG_COEF:      coef_r          <= cfg_data;
          hrds_pkg::REG_RATE_LOW:  lim_r.rate_low  <= cfg_data;
          hrds_pkg::REG_RATE_HIGH: lim_r.rate_high <= cfg_data;
          hrds_pkg::REG_VAR_LOW:   lim_r.var_low   <= cfg_data;
          hrds_pkg::REG_VAR_HIGH:  lim_r.var_high  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // State that persists between items; reset restores it to 60 bpm and normal.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r        <= hrds_pkg::RATE_RESET;
      last_class_r <= hrds_pkg::CLS_NORMAL;
      for (int i = 0; i < DEPTH; i++) begin
        past_r[i] <= hrds_pkg::RATE_RESET;
      end
    end else begin
      // The rounded average sits in the accumulator for the first filter cycle.
      if (state_r == ST_FIR && cnt_r == 4'd0) begin
        avg_r <= acc[31:16];
      end
      // The delay line advances once the filter has read every tap.
      if (state_r == ST_SCALE) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          past_r[i] <= past_r[i + 1];
        end
        past_r[DEPTH - 1] <= x_r;
      end
      if (finish) begin
        last_class_r <= dec.driver_class;
      end
    end
  end

  // Payload registers of the item in flight and of the result word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r    <= in_data.rate_sample;
      gaze_r <= in_data.gaze_class;
    end
    if (state_r == ST_SCALE) begin
      num_r <= scaled[36:7];
    end
    if (state_r == ST_DINIT) begin
      sat_r <= over;
    end
    if (finish) begin
      out_r.smoothed_rate    <= avg_r;
      out_r.variability_pct  <= pct;
      out_r.driver_class     <= dec.driver_class;
      out_r.display_symbol   <= dec.display_symbol;
      out_r.fixed_brightness <= dec.fixed_brightness;
      out_r.rule_hit         <= dec.rule_hit;
      out_r.alert            <= dec.alert;
    end
  end

  // A new result word only ever appears as the sequencer leaves DONE.
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside DONE");

  // The divider never runs past its sixteenth step.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count overran");

  // The alert flag agrees with the class and the rule flag of the same word.
  a_alert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alert ==
                   (out_data.rule_hit && (out_data.driver_class != hrds_pkg::CLS_NORMAL))))
    else $error("alert disagrees with driver class");

  // Without a matching rule the word shows no symbol and no fixed brightness.
  a_no_rule: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.rule_hit) |->
      (out_data.display_symbol == hrds_pkg::SYM_NONE && !out_data.fixed_brightness))
    else $error("display changed without a matching rule");

endmodule

// File: rtl/core/hrds_mac.sv
// Shared multiply-accumulate unit: signed 18-bit by unsigned 16-bit.
// Depends on hrds_pkg for the control struct.
module hrds_mac (
  input  logic                    clk,
  input  hrds_pkg::mac_ctrl_t     ctrl,
  input  logic signed [17:0]      op_a,
  input  logic [15:0]             op_b,
  output logic signed [34:0]      acc
);

  logic signed [34:0] prod;
  logic signed [34:0] base;
  logic signed [34:0] acc_r;

  assign prod = op_a * $signed({1'b0, op_b});
  // A fresh sum starts from the rounding half when the average is formed.
  assign base = ctrl.init ? (ctrl.round ? 35'sd32768 : 35'sd0) : acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= base + prod;
    end
  end

  assign acc = acc_r;

endmodule

// File: rtl/core/hrds_div.sv
// Restoring divider, one quotient bit a cycle while step is high, 32-by-16 bits.
// Depends on hrds_pkg for the control struct; the caller keeps the quotient in 16 bits.
module hrds_div (
  input  logic                 clk,
  input  hrds_pkg::div_ctrl_t  ctrl,
  input  logic [31:0]          dividend,
  input  logic [15:0]          divisor,
  output logic [15:0]          quotient
);

  logic [15:0] rem_r;
  logic [15:0] quo_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;

  assign trial = {rem_r, quo_r[15]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= dividend[31:16];
      quo_r <= dividend[15:0];
    end else if (ctrl.step) begin
      rem_r <= fits ? diff[15:0] : trial[15:0];
      quo_r <= {quo_r[14:0], fits};
    end
  end

  assign quotient = quo_r;

endmodule

// File: rtl/core/hrds_decide.sv
// Decision table: gaze, raw rate and variability to driver class and display.
// Depends on hrds_pkg for codes and structs.
module hrds_decide (
  input  logic [15:0]          rate,
  input  logic [2:0]           gaze,
  input  logic [15:0]          pct,
  input  hrds_pkg::limits_t    lim,
  input  logic [1:0]           last_class,
  output hrds_pkg::decision_t  dec
);

  logic away;
  logic below;
  logic above;
  logic pct_lo;
  logic pct_hi;

  assign away   = gaze inside {hrds_pkg::GAZE_LEFT, hrds_pkg::GAZE_RIGHT};
  assign below  = rate < lim.rate_low;
  assign above  = rate > lim.rate_high;
  assign pct_lo = pct < lim.var_low;
  assign pct_hi = pct > lim.var_high;

  always_comb begin
    dec                  = '0;
    dec.driver_class     = last_class;
    dec.display_symbol   = hrds_pkg::SYM_NONE;
    dec.rule_hit         = 1'b1;
    if (away && below) begin
      dec.driver_class   = hrds_pkg::CLS_STOP;
      dec.display_symbol = hrds_pkg::SYM_STOP;
    end else if (away && !above) begin
      if (pct_hi) begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_HEART;
      end else if (pct_lo) begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_STOP;
      end else begin
        dec.driver_class   = hrds_pkg::CLS_WARNING;
        dec.display_symbol = hrds_pkg::SYM_QUESTION;
      end
    end else if (gaze == hrds_pkg::GAZE_FOCUS) begin
      if (below) begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_HEART;
      end else if (above) begin
        if (pct_lo) begin
          dec.driver_class   = hrds_pkg::CLS_WARNING;
          dec.display_symbol = hrds_pkg::SYM_QUESTION;
        end else begin
          dec.driver_class   = hrds_pkg::CLS_STOP;
          dec.display_symbol = hrds_pkg::SYM_STOP;
        end
      end else if (pct_lo) begin
        dec.driver_class     = hrds_pkg::CLS_NORMAL;
        dec.display_symbol   = hrds_pkg::SYM_SMILE;
        dec.fixed_brightness = 1'b1;
      end else if (pct_hi) begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_STOP;
      end else begin
        dec.driver_class   = hrds_pkg::CLS_WARNING;
        dec.display_symbol = hrds_pkg::SYM_QUESTION;
      end
    end else if (gaze == hrds_pkg::GAZE_CLOSED) begin
      if (below) begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_STOP;
      end else if (above) begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_HEART;
      end else if (pct_lo) begin
        dec.driver_class   = hrds_pkg::CLS_WARNING;
        dec.display_symbol = hrds_pkg::SYM_QUESTION;
      end else begin
        dec.driver_class   = hrds_pkg::CLS_STOP;
        dec.display_symbol = hrds_pkg::SYM_HEART;
      end
    end else begin
      dec.rule_hit = 1'b0;
    end
    dec.alert = dec.rule_hit && (dec.driver_class != hrds_pkg::CLS_NORMAL);
  end

endmodule

// File: tb/heart_rate_driver_state_checker.sv
// Checker for the heart-rate driver-state block: watches all three channels,
// predicts each result word and compares it field by field. Depends on hrds_pkg.
`timescale 1ns / 100ps

module heart_rate_driver_state_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  hrds_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  hrds_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);

  logic [15:0] coef, rate_lo, rate_hi, var_lo, var_hi;
  logic [15:0] avg;
  logic [15:0] history [8];
  logic [1:0]  last_cls;
  int          deriv_tap [9];

  hrds_pkg::out_word_t states_due [$];
  hrds_pkg::out_word_t due;
  hrds_pkg::out_word_t seen;

  task automatic report(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Advances the average, the delay line and the last class by one sample
  // and returns the word the block should produce for it.
  task automatic advance_sample(input hrds_pkg::in_word_t w, output hrds_pkg::out_word_t r);
    longint unsigned acc, mag, den, pct;
    longint          sum;
    logic [15:0]     x, pct16;
    logic [2:0]      g;
    logic [1:0]      cls;
    logic [2:0]      sym;
    logic            fixed, hit;
    x = w.rate_sample;
    g = w.gaze_class;
    acc = 64'(coef) * 64'(avg) + (64'd65536 - 64'(coef)) * 64'(x) + 64'd32768;
    avg = acc[31:16];
    sum = 0;
    for (int i = 0; i < 8; i++)
      sum += longint'({48'd0, history[i]}) * deriv_tap[i];
    sum += longint'({48'd0, x}) * deriv_tap[8];
    for (int i = 0; i < 7; i++)
      history[i] = history[i + 1];
    history[7] = x;
    mag = (sum < 0) ? longint'(-sum) : longint'(sum);
    den = 64'(avg) * 64'd128;
    if (den == 0) begin
      pct = 64'(hrds_pkg::PCT_MAX);
    end else begin
      pct = (mag * 64'd100) / den;
      if (pct > 64'(hrds_pkg::PCT_MAX)) pct = 64'(hrds_pkg::PCT_MAX);
    end
    pct16 = pct[15:0];

    cls = last_cls;
    sym = hrds_pkg::SYM_NONE;
    fixed = 1'b0;
    hit = 1'b1;
    if ((g == hrds_pkg::GAZE_LEFT || g == hrds_pkg::GAZE_RIGHT) && x < rate_lo) begin
      cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_STOP;
    end else if ((g == hrds_pkg::GAZE_LEFT || g == hrds_pkg::GAZE_RIGHT) && x <= rate_hi) begin
      if (pct16 > var_hi) begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_HEART;
      end else if (pct16 < var_lo) begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_STOP;
      end else begin
        cls = hrds_pkg::CLS_WARNING; sym = hrds_pkg::SYM_QUESTION;
      end
    end else if (g == hrds_pkg::GAZE_FOCUS) begin
      if (x < rate_lo) begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_HEART;
      end else if (x > rate_hi) begin
        if (pct16 < var_lo) begin
          cls = hrds_pkg::CLS_WARNING; sym = hrds_pkg::SYM_QUESTION;
        end else begin
          cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_STOP;
        end
      end else if (pct16 < var_lo) begin
        cls = hrds_pkg::CLS_NORMAL; sym = hrds_pkg::SYM_SMILE; fixed = 1'b1;
      end else if (pct16 > var_hi) begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_STOP;
      end else begin
        cls = hrds_pkg::CLS_WARNING; sym = hrds_pkg::SYM_QUESTION;
      end
    end else if (g == hrds_pkg::GAZE_CLOSED) begin
      if (x < rate_lo) begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_STOP;
      end else if (x > rate_hi) begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_HEART;
      end else if (pct16 < var_lo) begin
        cls = hrds_pkg::CLS_WARNING; sym = hrds_pkg::SYM_QUESTION;
      end else begin
        cls = hrds_pkg::CLS_STOP; sym = hrds_pkg::SYM_HEART;
      end
    end else begin
      hit = 1'b0;
    end
    last_cls = cls;

    r.smoothed_rate    = avg;
    r.variability_pct  = pct16;
    r.driver_class     = cls;
    r.display_symbol   = sym;
    r.fixed_brightness = fixed;
    r.rule_hit         = hit;
    r.alert            = hit && (cls != hrds_pkg::CLS_NORMAL);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coef     = hrds_pkg::COEF_RESET;
      rate_lo  = hrds_pkg::RATE_LOW_RESET;
      rate_hi  = hrds_pkg::RATE_HIGH_RESET;
      var_lo   = hrds_pkg::VAR_LOW_RESET;
      var_hi   = hrds_pkg::VAR_HIGH_RESET;
      avg      = hrds_pkg::RATE_RESET;
      last_cls = hrds_pkg::CLS_NORMAL;
      for (int i = 0; i < 8; i++) history[i] = hrds_pkg::RATE_RESET;
      deriv_tap = '{-546, -2185, -1638, -1092, 0, 546, 1092, 1638, 2185};
      states_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hrds_pkg::REG_COEF:      coef    = cfg_data;
          hrds_pkg::REG_RATE_LOW:  rate_lo = cfg_data;
          hrds_pkg::REG_RATE_HIGH: rate_hi = cfg_data;
          hrds_pkg::REG_VAR_LOW:   var_lo  = cfg_data;
          hrds_pkg::REG_VAR_HIGH:  var_hi  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_sample(in_data, due);
        states_due.push_back(due);
      end
      if (out_valid && out_ready) begin
        seen = out_data;
        if (states_due.size() == 0) begin
          report("result word arrived with nothing outstanding");
        end else begin
          due = states_due.pop_front();
          compare_field("smoothed_rate", seen.smoothed_rate, due.smoothed_rate);
          compare_field("variability_pct", seen.variability_pct, due.variability_pct);
          compare_field("driver_class", 16'(seen.driver_class), 16'(due.driver_class));
          compare_field("display_symbol", 16'(seen.display_symbol),
                        16'(due.display_symbol));
          compare_field("fixed_brightness", 16'(seen.fixed_brightness),
                        16'(due.fixed_brightness));
          compare_field("rule_hit", 16'(seen.rule_hit), 16'(due.rule_hit));
          compare_field("alert", 16'(seen.alert), 16'(due.alert));
        end
      end
    end
    pending = states_due.size();
  end

endmodule

// File: tb/heart_rate_driver_state_top_tb.sv
// Top of the heart-rate driver-state testbench: clock, reset, stimulus and verdict.
// Depends on hrds_pkg, heart_rate_driver_state_top and heart_rate_driver_state_checker.
`timescale 1ns / 100ps

module heart_rate_driver_state_top_tb;

  // Gaze codes beyond those the package names: face error, then the unused codes.
  localparam logic [2:0] GAZE_FACE_ERROR = 3'd4;
  localparam logic [2:0] GAZE_LAST       = 3'd7;

  // Margin allowed after the last expected result before registers change
  // or the run ends.
  localparam int SETTLE_CYCLES = 40;
  // Length of the long receiver hold-off used to back the block up.
  localparam int HOLD_CYCLES   = 400;
  // Generous bound on the whole run: the slowest legal run is far shorter.
  localparam int CYCLE_LIMIT   = 600000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  hrds_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_ready;
  hrds_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [15:0]         cfg_data;

  logic       hold_req;
  int         fail_count;
  int         pending;
  int         cycles;

  // State of the random heart-rate walk that shapes most of the stimulus.
  int         walk_rate;
  int         walk_step;
  logic [2:0] walk_gaze;

  hrds_pkg::in_word_t plan [$];

  heart_rate_driver_state_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  heart_rate_driver_state_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a run that hangs anywhere ends here as a failure.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("heart_rate_driver_state_top_tb NOT OK");
      $finish;
    end
  end

  // The receiver runs its own stall pattern. It switches at random between
  // always ready, a coin toss each cycle, and mostly ready with occasional
  // stalls of random length. A pulse on hold_req, seen at a rising edge,
  // starts the long hold-off, which it counts down itself.
  initial begin : result_sink
    int hold_left;
    int stall_left;
    int mode;
    int mode_left;
    hold_left  = 0;
    stall_left = 0;
    mode       = 0;
    mode_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) hold_left = HOLD_CYCLES;
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
              if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 40);
            end
          end
        endcase
      end
    end
  end

  function automatic hrds_pkg::in_word_t word(input logic [15:0] rate,
                                              input logic [2:0] gaze);
    hrds_pkg::in_word_t w;
    w.rate_sample = rate;
    w.gaze_class  = gaze;
    return w;
  endfunction

  // Next sample of the walk. Most samples drift by a bounded step with a gaze
  // that changes now and then; a few jump to a new rate, and a few are noise
  // over the full range of both fields.
  function automatic hrds_pkg::in_word_t next_sample();
    hrds_pkg::in_word_t w;
    int       pick;
    int       delta;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.rate_sample = 16'($urandom);
      w.gaze_class  = 3'($urandom_range(0, 7));
      return w;
    end
    if (pick < 13) begin
      walk_rate = $urandom_range(20, 200) * 256;
      walk_step = $urandom_range(0, 6000);
    end
    delta = $urandom_range(0, 2 * walk_step);
    walk_rate = walk_rate + delta - walk_step;
    if (walk_rate < 0) walk_rate = 0;
    if (walk_rate > 65535) walk_rate = 65535;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 9) == 0)
        walk_gaze = 3'($urandom_range(GAZE_FACE_ERROR, GAZE_LAST));
      else
        walk_gaze = 3'($urandom_range(hrds_pkg::GAZE_FOCUS, hrds_pkg::GAZE_CLOSED));
    end
    w.rate_sample = walk_rate[15:0];
    w.gaze_class  = walk_gaze;
    return w;
  endfunction

  // Offers every word of the plan in bursts of random length, with random
  // gaps between bursts unless gapless is set. Valid stays high across a
  // burst and is only dropped for a gap, so it never falls and rises in the
  // same step. Ends in the cycle after it drops valid.
  task automatic play_plan(input bit gapless);
    int burst;
    int gap;
    burst = 0;
    while (plan.size() > 0) begin
      if (burst == 0) begin
        gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      in_data  <= plan.pop_front();
      in_valid <= 1'b1;
      do @(posedge clk); while (!in_ready);
      @(negedge clk);
      burst--;
    end
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_plan(input int count);
    repeat (count) plan.push_back(next_sample());
  endtask

  // Waits at falling edges until the checker has nothing outstanding, then
  // lets the block settle.
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all five registers back to back; valid stays high between words.
  task automatic program_regs(input logic [15:0] coef, input logic [15:0] rate_lo,
                              input logic [15:0] rate_hi, input logic [15:0] var_lo,
                              input logic [15:0] var_hi);
    logic [15:0] vals [5];
    logic [2:0]  idx  [5];
    vals = '{coef, rate_lo, rate_hi, var_lo, var_hi};
    idx  = '{hrds_pkg::REG_COEF, hrds_pkg::REG_RATE_LOW, hrds_pkg::REG_RATE_HIGH,
             hrds_pkg::REG_VAR_LOW, hrds_pkg::REG_VAR_HIGH};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // A realistic setting: rate limits around resting values and variability
  // limits spread widely, usually in the right order.
  task automatic program_random_regs();
    logic [15:0] lo;
    lo = 16'($urandom_range(0, 16000));
    program_regs(($urandom_range(0, 3) == 0) ? hrds_pkg::COEF_RESET : 16'($urandom),
                 16'($urandom_range(35, 70) * 256), 16'($urandom_range(80, 160) * 256),
                 lo, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16000))
                                                 : 16'(lo + $urandom_range(0, 8000)));
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = hrds_pkg::REG_COEF;
    cfg_data  = '0;
    hold_req  = 1'b0;
    walk_rate = 60 * 256;
    walk_step = 800;
    walk_gaze = hrds_pkg::GAZE_FOCUS;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset settings: a steady rate, both rate
    // extremes, samples on and just beyond each limit with gaze away, on
    // each limit in focus, eyes closed, face error, three unused codes.
    plan.push_back(word(hrds_pkg::RATE_RESET, hrds_pkg::GAZE_FOCUS));
    plan.push_back(word(hrds_pkg::RATE_RESET, hrds_pkg::GAZE_FOCUS));
    plan.push_back(word(16'd0, hrds_pkg::GAZE_FOCUS));
    plan.push_back(word(16'hFFFF, hrds_pkg::GAZE_FOCUS));
    plan.push_back(word(hrds_pkg::RATE_LOW_RESET, hrds_pkg::GAZE_LEFT));
    plan.push_back(word(hrds_pkg::RATE_HIGH_RESET, hrds_pkg::GAZE_RIGHT));
    plan.push_back(word(hrds_pkg::RATE_LOW_RESET - 16'd1, hrds_pkg::GAZE_LEFT));
    plan.push_back(word(hrds_pkg::RATE_HIGH_RESET + 16'd1, hrds_pkg::GAZE_RIGHT));
    plan.push_back(word(16'd30000, hrds_pkg::GAZE_LEFT));
    plan.push_back(word(16'd5000, hrds_pkg::GAZE_CLOSED));
    plan.push_back(word(hrds_pkg::RATE_RESET, hrds_pkg::GAZE_CLOSED));
    plan.push_back(word(16'd40000, hrds_pkg::GAZE_CLOSED));
    for (logic [3:0] g = {1'b0, GAZE_FACE_ERROR}; g <= {1'b0, GAZE_LAST}; g++)
      plan.push_back(word(hrds_pkg::RATE_RESET, g[2:0]));
    plan.push_back(word(hrds_pkg::RATE_HIGH_RESET, hrds_pkg::GAZE_FOCUS));
    plan.push_back(word(hrds_pkg::RATE_LOW_RESET, hrds_pkg::GAZE_FOCUS));
    play_plan(1'b0);

    // Extreme settings: with a zero weight the average follows the sample,
    // so a zero sample gives a zero average, which drives the percentage
    // into saturation; a full-scale step lies between two such samples.
    wait_drained();
    program_regs(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    plan.push_back(word(16'd0, hrds_pkg::GAZE_FOCUS));
    plan.push_back(word(16'hFFFF, hrds_pkg::GAZE_CLOSED));
    plan.push_back(word(16'd0, hrds_pkg::GAZE_RIGHT));
    fill_plan(90);
    play_plan(1'b0);

    // Heaviest weight with every limit pair crossed.
    wait_drained();
    program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    fill_plan(100);
    play_plan(1'b0);

    // Back to the defaults. The receiver holds off for a long stretch while
    // the sender keeps offering words, so the block backs up and stalls.
    wait_drained();
    program_regs(hrds_pkg::COEF_RESET, hrds_pkg::RATE_LOW_RESET, hrds_pkg::RATE_HIGH_RESET,
                 hrds_pkg::VAR_LOW_RESET, hrds_pkg::VAR_HIGH_RESET);
    hold_req <= 1'b1;
    @(negedge clk);
    hold_req <= 1'b0;
    fill_plan(30);
    play_plan(1'b1);
    fill_plan(70);
    play_plan(1'b0);

    // Random settings. In one phase the sender stops part way through until
    // every outstanding result has come back.
    for (int phase = 0; phase < 5; phase++) begin
      wait_drained();
      program_random_regs();
      fill_plan(55);
      play_plan(1'b0);
      if (phase == 2) wait_drained();
      fill_plan(55);
      play_plan(1'b0);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("heart_rate_driver_state_top_tb OK");
    end else begin
      $display("heart_rate_driver_state_top_tb NOT OK");
    end
    $finish;
  end

endmodule
